### design/mtp_pkg.sv
// Shared types and constants for the majority trend prefetcher.
package mtp_pkg;

  localparam int HISTORY_DEPTH_DEF   = 32;
  localparam int WINDOW_SPLITS_DEF   = 4;
  localparam int BLOCKS_PER_PAGE_DEF = 4096;

  // Largest window in pages, and the cap value after reset.
  localparam int WINDOW_LIMIT     = 64;
  localparam int MAX_WINDOW_RESET = 8;

  typedef struct packed {
    logic        [47:0] access_offset;
    logic signed [31:0] access_delta;
    logic        [31:0] hit_counter;
  } access_t;

  typedef struct packed {
    logic               prefetch_valid;
    logic        [47:0] prefetch_base;
    logic signed [31:0] prefetch_stride;
    logic        [18:0] prefetch_blocks;
    logic        [6:0]  window_pages;
  } prefetch_t;

  // Status of the vote unit as seen by the top level.
  typedef struct packed {
    logic        done;
    logic        trend_valid;
    logic [31:0] trend;
  } vote_stat_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_SEARCH,
    TS_HOLD
  } top_state_t;

  typedef enum logic [1:0] {
    VS_IDLE,
    VS_PASS1,
    VS_PASS2,
    VS_DECIDE
  } vote_state_t;

endpackage

### design/mtp_hist_mem.sv
// Circular delta history memory with per-entry valid bits and registered read.
module mtp_hist_mem import mtp_pkg::*; #(
  parameter int DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [31:0]              wr_data,
  output logic [$clog2(DEPTH)-1:0] head,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [31:0]              rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic          vld [DEPTH];
  logic [AW-1:0] head_next;
  logic [31:0]   rd_word;
  logic          rd_vld;

  assign head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (wr_en) begin
      head           <= head_next;
      vld[head_next] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head_next] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

  // Entries never written since reset read as zero.
  assign rd_data = rd_vld ? rd_word : '0;

endmodule

### design/mtp_window.sv
// Window size computation from new hits, with the last hit count and window held.
module mtp_window import mtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        upd,
  input  logic [31:0] delta,
  input  logic [31:0] hit_counter,
  input  logic [6:0]  win_cap_cfg,
  input  logic        trend_valid,
  input  logic [31:0] trend,
  output logic [6:0]  win
);

  localparam int LIM_BITS = $clog2(WINDOW_LIMIT);

  logic [31:0] prev_hits;
  logic [6:0]  prev_window;

  always_comb begin
    logic [31:0] hits;
    logic [6:0]  cap;
    logic [7:0]  raw;
    logic [6:0]  capped;
    logic [6:0]  half;
    hits = hit_counter - prev_hits;
    cap  = (win_cap_cfg > 7'(WINDOW_LIMIT)) ? 7'(WINDOW_LIMIT) : win_cap_cfg;
    if (hits == '0) begin
      raw = (trend_valid && (delta == trend)) ? 8'd1 : 8'd0;
    end else if (hits[31:LIM_BITS] != '0) begin
      raw = 8'(2 * WINDOW_LIMIT);
    end else begin
      // Smallest power of two strictly above the hit count.
      raw = 8'd1;
      for (int i = 0; i < LIM_BITS; i++) begin
        if (hits[i]) begin
          raw = 8'd1 << (i + 1);
        end
      end
    end
    capped = (raw > {1'b0, cap}) ? cap : raw[6:0];
    half   = prev_window >> 1;
    win    = (capped < half) ? half : capped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_hits   <= '0;
      prev_window <= '0;
    end else if (upd) begin
      prev_hits   <= hit_counter;
      prev_window <= win;
    end
  end

endmodule

### design/mtp_vote.sv
// Majority vote sequencer: one shared comparator walks the history twice per window.
module mtp_vote import mtp_pkg::*; #(
  parameter int DEPTH  = HISTORY_DEPTH_DEF,
  parameter int SPLITS = WINDOW_SPLITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [$clog2(DEPTH)-1:0] head,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [31:0]              rd_data,
  output vote_stat_t               stat
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int W_FIRST = (DEPTH / SPLITS == 0) ? 1 : DEPTH / SPLITS;

  vote_state_t state, state_next;

  logic [CW-1:0] win_cnt;
  logic [CW-1:0] issue_cnt;
  logic [CW-1:0] proc_cnt;
  logic [AW-1:0] rp;
  logic          rd_pending;
  logic [31:0]   cand;
  logic [CW-1:0] votes;
  logic [CW-1:0] match_cnt;
  logic          trend_valid;
  logic [31:0]   trend;
  logic          done;

  logic [31:0]   cmp_b;
  logic          cmp_eq;
  logic [CW:0]   win_dbl;
  logic          found_raw;
  logic          found;
  logic          pass_done;
  logic          in_pass;

  // The one comparator: against history entries in the passes, against the
  // latched trend when deciding.
  assign cmp_b  = (state == VS_DECIDE) ? trend : rd_data;
  assign cmp_eq = (cand == cmp_b);

  assign in_pass   = (state == VS_PASS1) || (state == VS_PASS2);
  assign rd_en     = in_pass && (issue_cnt < win_cnt);
  assign rd_addr   = (issue_cnt == '0) ? head :
                     ((rp == '0) ? AW'(DEPTH - 1) : rp - 1'b1);
  assign pass_done = (proc_cnt == win_cnt);

  assign win_dbl   = {win_cnt, 1'b0};
  assign found_raw = (match_cnt > (win_cnt >> 1));
  assign found     = found_raw && (!trend_valid || cmp_eq);

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      VS_IDLE: begin
        if (start) begin
          state_next = VS_PASS1;
        end
      end
      VS_PASS1: begin
        if (pass_done) begin
          state_next = VS_PASS2;
        end
      end
      VS_PASS2: begin
        if (pass_done) begin
          state_next = VS_DECIDE;
        end
      end
      VS_DECIDE: begin
        if (!found && (win_dbl <= (CW + 1)'(DEPTH))) begin
          state_next = VS_PASS1;
        end else begin
          state_next = VS_IDLE;
          done       = 1'b1;
        end
      end
      default: state_next = VS_IDLE;
    endcase
  end

  assign stat = '{done: done, trend_valid: trend_valid, trend: trend};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= VS_IDLE;
      rd_pending  <= 1'b0;
      trend_valid <= 1'b0;
      trend       <= '0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_en;
      if (state == VS_DECIDE && found_raw && !trend_valid) begin
        trend_valid <= 1'b1;
        trend       <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rp        <= rd_addr;
      issue_cnt <= issue_cnt + 1'b1;
    end
    if (rd_pending) begin
      proc_cnt <= proc_cnt + 1'b1;
      if (state == VS_PASS1) begin
        if (votes == '0) begin
          cand  <= rd_data;
          votes <= CW'(1);
        end else if (cmp_eq) begin
          votes <= votes + 1'b1;
        end else begin
          votes <= votes - 1'b1;
        end
      end else if (cmp_eq) begin
        match_cnt <= match_cnt + 1'b1;
      end
    end
    unique case (state)
      VS_IDLE: begin
        win_cnt   <= CW'(W_FIRST);
        issue_cnt <= '0;
        proc_cnt  <= '0;
        votes     <= '0;
      end
      VS_PASS1: begin
        if (pass_done) begin
          issue_cnt <= '0;
          proc_cnt  <= '0;
          match_cnt <= '0;
        end
      end
      VS_PASS2: begin
      end
      VS_DECIDE: begin
        win_cnt   <= win_dbl[CW-1:0];
        issue_cnt <= '0;
        proc_cnt  <= '0;
        votes     <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

### design/majority_trend_prefetcher.sv
// Top level of the majority trend prefetcher.
//
// One item per access comes in on in_valid / in_stall with its offset, delta
// and running hit count; exactly one result item leaves on out_valid /
// out_stall for each one. An item is taken when valid is high and stall low.
// in_stall is high from the cycle after an item is taken until its result has
// moved into the output register, so one item is worked on at a time.
// When the window comes out as zero the vote is skipped: the item goes
// through the hold state into the output register. Otherwise the vote unit
// walks the delta history memory, one entry per cycle through its single
// read port, twice for each vote window size W it tries, with sizes starting
// at HISTORY_DEPTH / WINDOW_SPLITS and doubling up to HISTORY_DEPTH.
// The output register holds its item while out_stall is high; the next input
// item is still taken meanwhile, and its result waits inside until the output
// register frees up. A synchronous reset clears the history, the latched
// trend, the hit and window memory and sets the window cap to 8 pages. The
// cap is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module majority_trend_prefetcher import mtp_pkg::*; #(
  parameter int HISTORY_DEPTH   = HISTORY_DEPTH_DEF,
  parameter int WINDOW_SPLITS   = WINDOW_SPLITS_DEF,
  parameter int BLOCKS_PER_PAGE = BLOCKS_PER_PAGE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  access_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output prefetch_t out_data,
  input  logic      cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  top_state_t state, state_next;

  logic [6:0]    max_window_pages;
  logic          accept;
  logic [6:0]    win_calc;
  logic [6:0]    win;
  logic [47:0]   offset;
  logic [AW-1:0] head;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  vote_stat_t    stat;
  logic          load_out;
  logic          issue;
  logic [18:0]   blocks;
  prefetch_t     res;

  assign in_stall = (state != TS_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_window_pages <= 7'(MAX_WINDOW_RESET);
    end else if (cfg_wr_en) begin
      max_window_pages <= cfg_wr_data;
    end
  end

  mtp_hist_mem #(
    .DEPTH (HISTORY_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (in_data.access_delta),
    .head    (head),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mtp_window u_window (
    .clk         (clk),
    .rst         (rst),
    .upd         (accept),
    .delta       (in_data.access_delta),
    .hit_counter (in_data.hit_counter),
    .win_cap_cfg (max_window_pages),
    .trend_valid (stat.trend_valid),
    .trend       (stat.trend),
    .win         (win_calc)
  );

  mtp_vote #(
    .DEPTH  (HISTORY_DEPTH),
    .SPLITS (WINDOW_SPLITS)
  ) u_vote (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && (win_calc != '0)),
    .head    (head),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      offset <= in_data.access_offset;
      win    <= win_calc;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      TS_IDLE: begin
        if (accept) begin
          state_next = (win_calc != '0) ? TS_SEARCH : TS_HOLD;
        end
      end
      TS_SEARCH: begin
        if (stat.done) begin
          state_next = TS_HOLD;
        end
      end
      TS_HOLD: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = TS_IDLE;
        end
      end
      default: state_next = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A run goes out only with a nonzero window and a latched trend.
  assign issue  = (win != '0) && stat.trend_valid;
  assign blocks = 19'(32'(win) * 32'(BLOCKS_PER_PAGE));

  always_comb begin
    res.prefetch_valid  = issue;
    res.prefetch_base   = issue ? offset : '0;
    res.prefetch_stride = issue ? stat.trend : '0;
    res.prefetch_blocks = issue ? blocks : '0;
    res.window_pages    = win;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule

### design/mtp_checker.sv
// Port-level checks for the majority trend prefetcher, bound to the top level.
module mtp_checker import mtp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input prefetch_t out_data
);

  // The block takes one item at a time.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("item accepted while the previous one was still in work");

  // Without a run, every run field reads zero.
  a_idle_fields_zero: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_data.prefetch_valid) |->
      (out_data.prefetch_base == '0 && out_data.prefetch_stride == '0 &&
       out_data.prefetch_blocks == '0)
  ) else $error("run fields nonzero on a result without a run");

  // A run always carries a window between one page and the limit.
  a_run_window: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && out_data.prefetch_valid) |->
      (out_data.window_pages != '0 && out_data.window_pages <= 7'(WINDOW_LIMIT))
  ) else $error("run issued with a window out of range");

  // A stalled result stays put.
  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data))
  ) else $error("stalled result changed or dropped");

  // Reset empties the output register.
  a_reset_out: assert property (
    @(posedge clk)
    rst |=> !out_valid
  ) else $error("result shown right after reset");

endmodule

bind majority_trend_prefetcher mtp_checker u_mtp_checker (.*);
